FILE: rtl/spsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spsm_pkg;

    localparam int IDX_W       = 12;
    localparam int DATA_W      = 32;
    localparam int DIM_W       = 5;
    localparam int ZPOS_W      = 12;
    localparam int STRIDE_W    = 2 * DIM_W;
    localparam int TAPS        = 7;
    localparam int TAP_W       = 3;
    localparam int ACC_W       = 52;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int QDEPTH      = 2;
    localparam int MAX_DIM_DEF = 16;

    localparam logic [TAP_W-1:0] LAST_TAP   = 3'd6;
    localparam logic [TAP_W-1:0] CENTRE_TAP = 3'd3;

    // command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // register indexes (word address)
    localparam logic [2:0] REG_NX   = 3'd0;
    localparam logic [2:0] REG_NY   = 3'd1;
    localparam logic [2:0] REG_NZ   = 3'd2;
    localparam logic [2:0] REG_DX   = 3'd3;
    localparam logic [2:0] REG_DY   = 3'd4;
    localparam logic [2:0] REG_DZ   = 3'd5;
    localparam logic [2:0] REG_MASK = 3'd6;

    // tap axes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_C = 2'd3;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV1,
        F_DIV2,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TAP,
        B_MUL1,
        B_MUL2,
        B_ACC,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic                     cmd;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] coef;
        logic signed [DATA_W-1:0] diag;
        logic signed [DATA_W-1:0] vec;
        logic [DIM_W-1:0]         px;
        logic [DIM_W-1:0]         py;
        logic [ZPOS_W-1:0]        pz;
    } qentry_t;

    typedef struct packed {
        logic [DIM_W-1:0] nx;
        logic [DIM_W-1:0] ny;
        logic [DIM_W-1:0] nz;
    } dims_t;

    function automatic logic [1:0] tap_axis(input logic [TAP_W-1:0] t);
        logic [1:0] a;
        unique case (t)
            3'd0, 3'd6: a = AXIS_Z;
            3'd1, 3'd5: a = AXIS_Y;
            3'd2, 3'd4: a = AXIS_X;
            default:    a = AXIS_C;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/spsm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module spsm_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  cmd,
    input  wire logic [spsm_pkg::IDX_W-1:0]            cell_index,
    input  wire logic signed [spsm_pkg::DATA_W-1:0]    cell_coef,
    input  wire logic signed [spsm_pkg::DATA_W-1:0]    cell_diag,
    input  wire logic signed [spsm_pkg::DATA_W-1:0]    vector_elem,
    input  wire spsm_pkg::dims_t                       dims,
    input  wire logic                                  q_full,
    output logic                                       q_push,
    output spsm_pkg::qentry_t                          q_wdata
);

    localparam int CNT_W = $clog2(spsm_pkg::IDX_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(spsm_pkg::IDX_W - 1);

    spsm_pkg::front_state_t state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [spsm_pkg::IDX_W-1:0]    num_reg, num_next;
    logic [spsm_pkg::DIM_W-1:0]    rem_reg, rem_next;
    spsm_pkg::qentry_t             ent_reg, ent_next;

    logic                          accept;
    logic [spsm_pkg::DIM_W:0]      trial;
    logic [spsm_pkg::DIM_W:0]      divisor;
    logic                          ge;
    logic [spsm_pkg::DIM_W:0]      diff;

    assign accept = start && (state_reg == spsm_pkg::F_IDLE);

    // one restoring-division step per cycle, shared by both divides
    assign divisor = (state_reg == spsm_pkg::F_DIV2) ? {1'b0, dims.ny} : {1'b0, dims.nx};
    assign trial   = {rem_reg, num_reg[spsm_pkg::IDX_W-1]};
    assign ge      = (trial >= divisor);
    assign diff    = trial - divisor;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spsm_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd == spsm_pkg::CMD_LOAD) ? spsm_pkg::F_PUSH
                                                             : spsm_pkg::F_DIV1;
                end
            end
            spsm_pkg::F_DIV1:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = spsm_pkg::F_DIV2;
            end
            spsm_pkg::F_DIV2:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = spsm_pkg::F_PUSH;
            end
            spsm_pkg::F_PUSH:
            begin
                if (!q_full)
                    state_next = spsm_pkg::F_IDLE;
            end
            default: state_next = spsm_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        ent_next = ent_reg;
        unique case (state_reg)
            spsm_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    ent_next.cmd  = cmd;
                    ent_next.idx  = cell_index;
                    ent_next.coef = cell_coef;
                    ent_next.diag = cell_diag;
                    ent_next.vec  = vector_elem;
                    ent_next.px   = '0;
                    ent_next.py   = '0;
                    ent_next.pz   = '0;
                    num_next      = cell_index;
                    rem_next      = '0;
                    cnt_next      = '0;
                end
            end
            spsm_pkg::F_DIV1, spsm_pkg::F_DIV2:
            begin
                num_next = {num_reg[spsm_pkg::IDX_W-2:0], ge};
                rem_next = ge ? diff[spsm_pkg::DIM_W-1:0] : trial[spsm_pkg::DIM_W-1:0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (state_reg == spsm_pkg::F_DIV1)
                    begin
                        ent_next.px = ge ? diff[spsm_pkg::DIM_W-1:0]
                                         : trial[spsm_pkg::DIM_W-1:0];
                    end
                    else
                    begin
                        ent_next.py = ge ? diff[spsm_pkg::DIM_W-1:0]
                                         : trial[spsm_pkg::DIM_W-1:0];
                        ent_next.pz = {num_reg[spsm_pkg::IDX_W-2:0], ge};
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_comb
    begin
        busy    = (state_reg != spsm_pkg::F_IDLE);
        q_push  = (state_reg == spsm_pkg::F_PUSH) && !q_full;
        q_wdata = ent_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spsm_pkg::F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        ent_reg <= ent_next;
    end

endmodule
`default_nettype wire

FILE: rtl/spsm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module spsm_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire spsm_pkg::qentry_t wdata,
    input  wire logic              pop,
    output spsm_pkg::qentry_t      rdata,
    output logic                   full,
    output logic                   empty
);

    localparam int PTR_W = (spsm_pkg::QDEPTH > 1) ? $clog2(spsm_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(spsm_pkg::QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(spsm_pkg::QDEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(spsm_pkg::QDEPTH);

    spsm_pkg::qentry_t slot_reg [spsm_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

endmodule
`default_nettype wire

FILE: rtl/spsm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module spsm_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  q_empty,
    input  wire spsm_pkg::qentry_t                     q_rdata,
    output logic                                       q_pop,
    input  wire spsm_pkg::dims_t                       dims,
    input  wire logic signed [spsm_pkg::DATA_W-1:0]    delta_x,
    input  wire logic signed [spsm_pkg::DATA_W-1:0]    delta_y,
    input  wire logic signed [spsm_pkg::DATA_W-1:0]    delta_z,
    input  wire logic [spsm_pkg::TAPS-1:0]             sign_mask,
    output logic                                       done,
    output logic [spsm_pkg::IDX_W-1:0]                 out_index,
    output logic signed [spsm_pkg::DATA_W-1:0]         product_value,
    output logic                                       saturated
);

    localparam int DEPTH = 1 << spsm_pkg::IDX_W;
    localparam int SH_W  = spsm_pkg::PROD_W - 16;
    localparam logic signed [spsm_pkg::ACC_W-1:0] ACC_MAX =
        spsm_pkg::ACC_W'(64'sd2147483647);
    localparam logic signed [spsm_pkg::ACC_W-1:0] ACC_MIN =
        spsm_pkg::ACC_W'(-64'sd2147483648);
    localparam logic signed [SH_W-1:0] P1_MAX = SH_W'(64'sd2147483647);
    localparam logic signed [SH_W-1:0] P1_MIN = SH_W'(-64'sd2147483648);

    logic [spsm_pkg::DATA_W-1:0] coef_mem [DEPTH];
    logic [spsm_pkg::DATA_W-1:0] diag_mem [DEPTH];
    logic [spsm_pkg::DATA_W-1:0] vec_mem  [DEPTH];

    spsm_pkg::back_state_t state_reg, state_next;
    logic [spsm_pkg::TAP_W-1:0]          tap_reg, tap_next;
    spsm_pkg::qentry_t                   ent_reg, ent_next;
    logic signed [spsm_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic                                flag_reg, flag_next;
    logic signed [spsm_pkg::DATA_W-1:0]  delta_reg, delta_next;
    logic                                centre_reg, centre_next;
    logic signed [spsm_pkg::PROD_W-1:0]  prod1_reg, prod2_reg;
    logic signed [spsm_pkg::DATA_W-1:0]  coef_rd_reg, diag_rd_reg, vec_rd_reg;

    logic                                wr_en, rd_en;
    logic [1:0]                          axis;
    logic                                down;
    logic                                tap_ok;
    logic [spsm_pkg::STRIDE_W-1:0]       nxy;
    logic [spsm_pkg::IDX_W-1:0]          stride;
    logic [spsm_pkg::IDX_W-1:0]          nb_addr;
    logic signed [spsm_pkg::DATA_W-1:0]  delta_sel;
    logic signed [spsm_pkg::DATA_W-1:0]  a_val;
    logic signed [SH_W-1:0]              p1_wide;
    logic signed [spsm_pkg::DATA_W-1:0]  p1;
    logic                                p1_clip;
    logic signed [SH_W-1:0]              p2;
    logic signed [spsm_pkg::ACC_W-1:0]   term;
    logic                                in_range;
    logic                                acc_hi, acc_lo;

    assign nxy      = dims.nx * dims.ny;
    assign axis     = spsm_pkg::tap_axis(tap_reg);
    assign down     = (tap_reg < spsm_pkg::CENTRE_TAP);
    assign in_range = (q_rdata.pz < spsm_pkg::ZPOS_W'(dims.nz));

    // neighbour selection for the current tap
    always_comb
    begin
        tap_ok    = 1'b1;
        stride    = '0;
        delta_sel = delta_x;
        unique case (axis)
            spsm_pkg::AXIS_X:
            begin
                stride    = spsm_pkg::IDX_W'(1);
                delta_sel = delta_x;
                tap_ok    = down ? (ent_reg.px != '0)
                                 : ({1'b0, ent_reg.px} + 6'd1 < {1'b0, dims.nx});
            end
            spsm_pkg::AXIS_Y:
            begin
                stride    = spsm_pkg::IDX_W'(dims.nx);
                delta_sel = delta_y;
                tap_ok    = down ? (ent_reg.py != '0)
                                 : ({1'b0, ent_reg.py} + 6'd1 < {1'b0, dims.ny});
            end
            spsm_pkg::AXIS_Z:
            begin
                stride    = spsm_pkg::IDX_W'(nxy);
                delta_sel = delta_z;
                tap_ok    = down ? (ent_reg.pz != '0)
                                 : ({1'b0, ent_reg.pz} + 13'd1 <
                                    (spsm_pkg::ZPOS_W + 1)'(dims.nz));
            end
            default:
            begin
                stride    = '0;
                delta_sel = delta_x;
                tap_ok    = 1'b1;
            end
        endcase
    end

    assign nb_addr = down ? (ent_reg.idx - stride) : (ent_reg.idx + stride);

    assign q_pop = (state_reg == spsm_pkg::B_IDLE) && !q_empty;
    assign wr_en = q_pop && (q_rdata.cmd == spsm_pkg::CMD_LOAD);
    assign rd_en = (state_reg == spsm_pkg::B_TAP) && tap_ok;

    // arithmetic per stage
    assign a_val   = centre_reg ? diag_rd_reg : delta_reg;
    assign p1_wide = SH_W'(prod1_reg >>> 16);
    assign p1_clip = (p1_wide > P1_MAX) || (p1_wide < P1_MIN);
    assign p1      = (p1_wide > P1_MAX) ? P1_MAX[spsm_pkg::DATA_W-1:0]
                   : (p1_wide < P1_MIN) ? P1_MIN[spsm_pkg::DATA_W-1:0]
                   : p1_wide[spsm_pkg::DATA_W-1:0];
    assign p2      = SH_W'(prod2_reg >>> 16);
    assign term    = sign_mask[tap_reg] ? -spsm_pkg::ACC_W'(p2) : spsm_pkg::ACC_W'(p2);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spsm_pkg::B_IDLE:
            begin
                if (q_pop && (q_rdata.cmd == spsm_pkg::CMD_COMPUTE))
                    state_next = in_range ? spsm_pkg::B_TAP : spsm_pkg::B_EMIT;
            end
            spsm_pkg::B_TAP:
            begin
                if (tap_ok)
                    state_next = spsm_pkg::B_MUL1;
                else if (tap_reg == spsm_pkg::LAST_TAP)
                    state_next = spsm_pkg::B_EMIT;
            end
            spsm_pkg::B_MUL1: state_next = spsm_pkg::B_MUL2;
            spsm_pkg::B_MUL2: state_next = spsm_pkg::B_ACC;
            spsm_pkg::B_ACC:
            begin
                state_next = (tap_reg == spsm_pkg::LAST_TAP) ? spsm_pkg::B_EMIT
                                                             : spsm_pkg::B_TAP;
            end
            spsm_pkg::B_EMIT: state_next = spsm_pkg::B_IDLE;
            default:          state_next = spsm_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        tap_next    = tap_reg;
        ent_next    = ent_reg;
        acc_next    = acc_reg;
        flag_next   = flag_reg;
        delta_next  = delta_reg;
        centre_next = centre_reg;
        unique case (state_reg)
            spsm_pkg::B_IDLE:
            begin
                if (q_pop)
                begin
                    ent_next  = q_rdata;
                    tap_next  = '0;
                    acc_next  = '0;
                    flag_next = 1'b0;
                end
            end
            spsm_pkg::B_TAP:
            begin
                delta_next  = delta_sel;
                centre_next = (axis == spsm_pkg::AXIS_C);
                if (!tap_ok)
                    tap_next = tap_reg + spsm_pkg::TAP_W'(1);
            end
            spsm_pkg::B_MUL2:
            begin
                flag_next = flag_reg | p1_clip;
            end
            spsm_pkg::B_ACC:
            begin
                acc_next = acc_reg + term;
                tap_next = tap_reg + spsm_pkg::TAP_W'(1);
            end
            default:
            begin
                tap_next = tap_reg;
            end
        endcase
    end

    // result drive
    always_comb
    begin
        acc_hi        = (acc_reg > ACC_MAX);
        acc_lo        = (acc_reg < ACC_MIN);
        done          = (state_reg == spsm_pkg::B_EMIT);
        out_index     = ent_reg.idx;
        product_value = acc_hi ? ACC_MAX[spsm_pkg::DATA_W-1:0]
                      : acc_lo ? ACC_MIN[spsm_pkg::DATA_W-1:0]
                      : acc_reg[spsm_pkg::DATA_W-1:0];
        saturated     = flag_reg | acc_hi | acc_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spsm_pkg::B_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg    <= ent_next;
        acc_reg    <= acc_next;
        flag_reg   <= flag_next;
        delta_reg  <= delta_next;
        centre_reg <= centre_next;
        prod1_reg  <= a_val * coef_rd_reg;
        prod2_reg  <= p1 * vec_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            coef_mem[q_rdata.idx] <= q_rdata.coef;
        if (rd_en)
            coef_rd_reg <= coef_mem[nb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            diag_mem[q_rdata.idx] <= q_rdata.diag;
        if (rd_en)
            diag_rd_reg <= diag_mem[nb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            vec_mem[q_rdata.idx] <= q_rdata.vec;
        if (rd_en)
            vec_rd_reg <= vec_mem[nb_addr];
    end

endmodule
`default_nettype wire

FILE: rtl/seven_point_stencil_matvec.sv
`timescale 1ns / 1ps
`default_nettype none
// Seven-point stencil row product over an nx*ny*nz grid, signed Q16.16.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. cmd 0 loads coefficient, diagonal and vector element of
// cell_index; cmd 1 asks for the row product of cell_index.
// Result channel: done is high for exactly one cycle with out_index,
// product_value and saturated; the receiver cannot stall, so the result is
// simply taken in that cycle. Loads give no result.
// Configuration: APB, pready tied high, registers at 4*i (grid_nx, grid_ny,
// grid_nz, delta_x, delta_y, delta_z, tap_sign_mask). Write only when idle.
// For a compute the front finds the x, y, z position with two 12-step
// restoring divides; a load needs no divide. A two-entry queue decouples
// the front from the back, which skips each tap outside the mesh and takes
// every live tap through store read, two multiplies with a register after
// each, and accumulate. The front can thus take a new transaction while
// the back still works on earlier ones, as long as the queue has room.
// Reset: state machines and queue clear, registers take their defaults;
// the cell stores are undefined until loaded.
module seven_point_stencil_matvec #(
    parameter int MAX_DIM = spsm_pkg::MAX_DIM_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  cmd,
    input  wire logic [spsm_pkg::IDX_W-1:0]            cell_index,
    input  wire logic signed [spsm_pkg::DATA_W-1:0]    cell_coef,
    input  wire logic signed [spsm_pkg::DATA_W-1:0]    cell_diag,
    input  wire logic signed [spsm_pkg::DATA_W-1:0]    vector_elem,
    output logic                                       done,
    output logic [spsm_pkg::IDX_W-1:0]                 out_index,
    output logic signed [spsm_pkg::DATA_W-1:0]         product_value,
    output logic                                       saturated,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [4:0]                            paddr,
    input  wire logic [31:0]                           pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready
);

    // clamp limit, as wide as the size registers
    localparam logic [spsm_pkg::DIM_W-1:0] DIM_LIM =
        (MAX_DIM > 31) ? 5'd31 : spsm_pkg::DIM_W'(MAX_DIM);
    localparam logic CLAMP_ON = (MAX_DIM < 31);

    logic [spsm_pkg::DIM_W-1:0]         nx_reg, ny_reg, nz_reg;
    logic signed [spsm_pkg::DATA_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [spsm_pkg::TAPS-1:0]          mask_reg;

    logic                               cfg_wr;
    logic [2:0]                         cfg_sel;
    spsm_pkg::dims_t                    dims;

    logic                               q_full, q_empty, q_push, q_pop;
    spsm_pkg::qentry_t                  q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg   <= 5'd16;
            ny_reg   <= 5'd16;
            nz_reg   <= 5'd16;
            dx_reg   <= 32'sd65536;
            dy_reg   <= 32'sd65536;
            dz_reg   <= 32'sd65536;
            mask_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                spsm_pkg::REG_NX:   nx_reg   <= pwdata[spsm_pkg::DIM_W-1:0];
                spsm_pkg::REG_NY:   ny_reg   <= pwdata[spsm_pkg::DIM_W-1:0];
                spsm_pkg::REG_NZ:   nz_reg   <= pwdata[spsm_pkg::DIM_W-1:0];
                spsm_pkg::REG_DX:   dx_reg   <= pwdata;
                spsm_pkg::REG_DY:   dy_reg   <= pwdata;
                spsm_pkg::REG_DZ:   dz_reg   <= pwdata;
                spsm_pkg::REG_MASK: mask_reg <= pwdata[spsm_pkg::TAPS-1:0];
                default:            mask_reg <= mask_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            spsm_pkg::REG_NX:   prdata = {27'd0, nx_reg};
            spsm_pkg::REG_NY:   prdata = {27'd0, ny_reg};
            spsm_pkg::REG_NZ:   prdata = {27'd0, nz_reg};
            spsm_pkg::REG_DX:   prdata = dx_reg;
            spsm_pkg::REG_DY:   prdata = dy_reg;
            spsm_pkg::REG_DZ:   prdata = dz_reg;
            spsm_pkg::REG_MASK: prdata = {25'd0, mask_reg};
            default:            prdata = '0;
        endcase
    end

    // a size of zero acts as one, anything above the limit as the limit
    function automatic logic [spsm_pkg::DIM_W-1:0] clamp_dim(
        input logic [spsm_pkg::DIM_W-1:0] d);
        logic [spsm_pkg::DIM_W-1:0] r;
        if (d == '0)
            r = 5'd1;
        else if (CLAMP_ON && (d > DIM_LIM))
            r = DIM_LIM;
        else
            r = d;
        return r;
    endfunction

    assign dims.nx = clamp_dim(nx_reg);
    assign dims.ny = clamp_dim(ny_reg);
    assign dims.nz = clamp_dim(nz_reg);

    spsm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .cell_index  (cell_index),
        .cell_coef   (cell_coef),
        .cell_diag   (cell_diag),
        .vector_elem (vector_elem),
        .dims        (dims),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    spsm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    spsm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .dims          (dims),
        .delta_x       (dx_reg),
        .delta_y       (dy_reg),
        .delta_z       (dz_reg),
        .sign_mask     (mask_reg),
        .done          (done),
        .out_index     (out_index),
        .product_value (product_value),
        .saturated     (saturated)
    );

endmodule
`default_nettype wire
